@@ rtl/pbdv_pkg.sv @@
// Shared types, constants and code arithmetic for the volume decoder.
package pbdv_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned MaxRes    = 4;

  // Run phase codes
  localparam logic [1:0] PhCtrl = 2'd0;
  localparam logic [1:0] PhCopy = 2'd1;
  localparam logic [1:0] PhDiff = 2'd2;
  localparam logic [1:0] PhRep  = 2'd3;

  // Result status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadCtrl = 2'd1;
  localparam logic [1:0] StNoRef   = 2'd2;

  // Control byte boundaries
  localparam logic [7:0] NarrowLitMax = 8'h20;
  localparam logic [7:0] NarrowDiffOf = 8'h20;
  localparam logic [7:0] WideDiffOf   = 8'h1f;
  localparam logic [7:0] NarrowRepMsk = 8'h7f;
  localparam logic [7:0] WideRepMsk   = 8'h1f;

  // One accepted byte's worth of results
  typedef struct packed {
    logic [1:0]                   last_idx;
    logic [MaxRes-1:0][15:0]      vox;
    logic [7:0]                   rep;
    logic [1:0]                   status;
  } pbdv_bundle_t;

  // Apply a 2-bit code: 0..2 add, 3 subtracts one
  function automatic logic [7:0] step2(input logic [7:0] v, input logic [1:0] c);
    logic [7:0] r;
    if (c == 2'd3) r = v - 8'd1;
    else           r = v + {6'd0, c};
    return r;
  endfunction

  // Apply a 3-bit code: 0..4 add, 5..7 subtract the low two bits
  function automatic logic [15:0] step3(input logic [15:0] v, input logic [2:0] c);
    logic [15:0] r;
    if (c > 3'd4) r = v - {14'd0, c[1:0]};
    else          r = v + {13'd0, c};
    return r;
  endfunction

endpackage

@@ rtl/pbdv_channels.sv @@
// Valid/ready channel interfaces for input bytes, results and configuration.
interface pbdv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_volume;
  modport source (output valid, output in_byte, output start_of_volume, input ready);
  modport sink   (input valid, input in_byte, input start_of_volume, output ready);
endinterface

interface pbdv_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] voxel;
  logic [7:0]  repeat_res;
  logic        last;
  logic [1:0]  status;
  modport source (output valid, output voxel, output repeat_res, output last,
                  output status, input ready);
  modport sink   (input valid, input voxel, input repeat_res, input last,
                  input status, output ready);
endinterface

interface pbdv_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] bytes_per_voxel;
  modport source (output valid, output bytes_per_voxel, input ready);
  modport sink   (input valid, input bytes_per_voxel, output ready);
endinterface

@@ rtl/pbdv_front.sv @@
// Front end: takes compressed bytes, tracks run state and forms result bundles.
module pbdv_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pbdv_in_if.sink               in_i,
  pbdv_cfg_if.sink              cfg_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output pbdv_pkg::pbdv_bundle_t bundle_o
);

  logic [1:0]  bpv_q;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  partial_q, partial_d;
  logic        bpos_q, bpos_d;
  logic [1:0]  cb_q, cb_d;
  logic [1:0]  cbc_q, cbc_d;
  logic [15:0] ref_q, ref_d;
  logic        refok_q, refok_d;
  logic [1:0]  err_q, err_d;

  logic        accept, sov, wide;
  logic [7:0]  b;
  logic [2:0]  sel;
  logic [1:0]  ph;
  logic [7:0]  rem;
  logic        bpos;
  logic [1:0]  cbc;
  logic [15:0] refv;
  logic        refok;
  logic [1:0]  err;
  logic [15:0] v;
  logic [3:0][7:0]  dn;
  logic [9:0]  acc;
  logic [2:0][15:0] dw;
  logic [1:0]  avail;
  logic [1:0]  kidx;

  assign in_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign accept = in_i.valid && in_i.ready;
  assign sov    = in_i.start_of_volume;
  assign b      = in_i.in_byte;
  assign sel    = b[7:5];
  assign wide   = bpv_q[1];

  // Start of volume clears run state, reference and error ahead of this byte
  assign ph    = sov ? pbdv_pkg::PhCtrl : phase_q;
  assign rem   = sov ? 8'd0 : rem_q;
  assign bpos  = sov ? 1'b0 : bpos_q;
  assign cbc   = sov ? 2'd0 : cbc_q;
  assign refv  = sov ? 16'd0 : ref_q;
  assign refok = sov ? 1'b0 : refok_q;
  assign err   = sov ? pbdv_pkg::StOk : err_q;

  // Narrow difference chain, four 2-bit codes LSB first
  assign dn[0] = pbdv_pkg::step2(refv[7:0], b[1:0]);
  assign dn[1] = pbdv_pkg::step2(dn[0], b[3:2]);
  assign dn[2] = pbdv_pkg::step2(dn[1], b[5:4]);
  assign dn[3] = pbdv_pkg::step2(dn[2], b[7:6]);

  // Wide difference chain, 3-bit codes MSB first from left-justified bits
  always_comb begin
    case (cbc)
      2'd1:    acc = {cb_q[0], b, 1'b0};
      2'd2:    acc = {cb_q, b};
      default: acc = {b, 2'b00};
    endcase
  end
  assign avail = (cbc == 2'd0) ? 2'd2 : 2'd3;
  assign dw[0] = pbdv_pkg::step3(refv, acc[9:7]);
  assign dw[1] = pbdv_pkg::step3(dw[0], acc[6:4]);
  assign dw[2] = pbdv_pkg::step3(dw[1], acc[3:1]);

  always_comb begin
    phase_d   = ph;
    rem_d     = rem;
    partial_d = partial_q;
    bpos_d    = bpos;
    cb_d      = cb_q;
    cbc_d     = cbc;
    ref_d     = refv;
    refok_d   = refok;
    err_d     = err;
    push_o    = 1'b0;
    bundle_o  = '0;
    bundle_o.rep    = 8'd1;
    bundle_o.status = pbdv_pkg::StOk;
    v    = 16'd0;
    kidx = 2'd0;

    if (err != pbdv_pkg::StOk) begin
      push_o          = accept;
      bundle_o.rep    = 8'd0;
      bundle_o.status = err;
    end else begin
      case (ph)
        pbdv_pkg::PhCtrl: begin
          bpos_d = 1'b0;
          cbc_d  = 2'd0;
          if (!wide) begin
            if (b <= pbdv_pkg::NarrowLitMax) begin
              phase_d = pbdv_pkg::PhCopy;
              rem_d   = b + 8'd1;
            end else if (!b[7]) begin
              if (refok) begin
                phase_d = pbdv_pkg::PhDiff;
                rem_d   = b - pbdv_pkg::NarrowDiffOf;
              end else begin
                err_d = pbdv_pkg::StNoRef;
              end
            end else begin
              phase_d = pbdv_pkg::PhRep;
              rem_d   = (b & pbdv_pkg::NarrowRepMsk) + 8'd1;
            end
          end else begin
            if (sel == 3'd0) begin
              phase_d = pbdv_pkg::PhCopy;
              rem_d   = b + 8'd1;
            end else if (sel inside {3'd1, 3'd2}) begin
              if (refok) begin
                phase_d = pbdv_pkg::PhDiff;
                rem_d   = b - pbdv_pkg::WideDiffOf;
              end else begin
                err_d = pbdv_pkg::StNoRef;
              end
            end else if (sel == 3'd7) begin
              phase_d = pbdv_pkg::PhRep;
              rem_d   = (b & pbdv_pkg::WideRepMsk) + 8'd2;
            end else begin
              err_d = pbdv_pkg::StBadCtrl;
            end
          end
          if (err_d != pbdv_pkg::StOk) begin
            // Error leaves run state untouched
            phase_d         = ph;
            rem_d           = rem;
            bpos_d          = bpos;
            cbc_d           = cbc;
            push_o          = accept;
            bundle_o.rep    = 8'd0;
            bundle_o.status = err_d;
          end
        end
        pbdv_pkg::PhCopy, pbdv_pkg::PhRep: begin
          if (wide && !bpos) begin
            partial_d = b;
            bpos_d    = 1'b1;
          end else begin
            v              = wide ? {b, partial_q} : {8'd0, b};
            bpos_d         = 1'b0;
            ref_d          = v;
            refok_d        = 1'b1;
            push_o         = accept;
            bundle_o.vox[0] = v;
            if (ph == pbdv_pkg::PhRep) begin
              bundle_o.rep = rem;
              phase_d      = pbdv_pkg::PhCtrl;
              rem_d        = 8'd0;
              cbc_d        = 2'd0;
            end else if (rem <= 8'd1) begin
              phase_d = pbdv_pkg::PhCtrl;
              rem_d   = 8'd0;
              cbc_d   = 2'd0;
            end else begin
              rem_d = rem - 8'd1;
            end
          end
        end
        default: begin
          push_o  = accept;
          refok_d = 1'b1;
          if (!wide) begin
            if (rem >= 8'd4)      kidx = 2'd3;
            else if (rem <= 8'd1) kidx = 2'd0;
            else                  kidx = 2'(rem - 8'd1);
            bundle_o.last_idx = kidx;
            for (int i = 0; i < pbdv_pkg::MaxRes; i++) begin
              bundle_o.vox[i] = {8'd0, dn[i]};
            end
            ref_d = {8'd0, dn[kidx]};
            cbc_d = 2'd0;
            if (rem <= 8'd4) begin
              phase_d = pbdv_pkg::PhCtrl;
              rem_d   = 8'd0;
              bpos_d  = 1'b0;
            end else begin
              rem_d = rem - 8'd4;
            end
          end else begin
            if (rem >= {6'd0, avail}) kidx = avail - 2'd1;
            else if (rem <= 8'd1)     kidx = 2'd0;
            else                      kidx = 2'(rem - 8'd1);
            bundle_o.last_idx = kidx;
            for (int i = 0; i < 3; i++) begin
              bundle_o.vox[i] = dw[i];
            end
            ref_d = dw[kidx];
            if (rem > {6'd0, avail}) begin
              rem_d = rem - {6'd0, avail};
              case (cbc)
                2'd1: begin
                  cbc_d = 2'd0;
                end
                2'd2: begin
                  cbc_d = 2'd1;
                  cb_d  = {1'b0, b[0]};
                end
                default: begin
                  cbc_d = 2'd2;
                  cb_d  = b[1:0];
                end
              endcase
            end else begin
              phase_d = pbdv_pkg::PhCtrl;
              rem_d   = 8'd0;
              bpos_d  = 1'b0;
              cbc_d   = 2'd0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpv_q   <= 2'd1;
      phase_q <= pbdv_pkg::PhCtrl;
      rem_q   <= 8'd0;
      bpos_q  <= 1'b0;
      cbc_q   <= 2'd0;
      ref_q   <= 16'd0;
      refok_q <= 1'b0;
      err_q   <= pbdv_pkg::StOk;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        bpv_q <= cfg_i.bytes_per_voxel;
      end
      if (accept) begin
        phase_q <= phase_d;
        rem_q   <= rem_d;
        bpos_q  <= bpos_d;
        cbc_q   <= cbc_d;
        ref_q   <= ref_d;
        refok_q <= refok_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      partial_q <= partial_d;
      cb_q      <= cb_d;
    end
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != pbdv_pkg::StOk && !(accept && sov)) |=> (err_q == $past(err_q)))
    else $error("error code changed without start of volume");
  a_err_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && err != pbdv_pkg::StOk) |-> (push_o && bundle_o.last_idx == 2'd0))
    else $error("held error must yield exactly one result");
`endif

endmodule

@@ rtl/pbdv_queue.sv @@
// Short bundle queue between the front end and the result serialiser.
module pbdv_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pbdv_pkg::pbdv_bundle_t push_data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   head_valid_o,
  output pbdv_pkg::pbdv_bundle_t head_o
);

  pbdv_pkg::pbdv_bundle_t entry_q [pbdv_pkg::FifoDepth];
  logic [pbdv_pkg::PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [pbdv_pkg::PtrW:0]   count_q;

  assign full_o       = (count_q == (pbdv_pkg::PtrW+1)'(pbdv_pkg::FifoDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");
`endif

endmodule

@@ rtl/pbdv_back.sv @@
// Back end: walks each queued bundle and drives one result per transaction.
module pbdv_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  pbdv_pkg::pbdv_bundle_t head_i,
  output logic                   pop_o,
  pbdv_out_if.source             out_o
);

  logic [1:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [15:0] voxel_q;
  logic [7:0]  rep_q;
  logic        last_q;
  logic [1:0]  status_q;
  logic        load, is_last;

  assign load    = head_valid_i && (!valid_q || out_o.ready);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (out_o.ready) valid_d = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      voxel_q  <= head_i.vox[idx_q];
      rep_q    <= head_i.rep;
      last_q   <= is_last;
      status_q <= head_i.status;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.voxel      = voxel_q;
  assign out_o.repeat_res = rep_q;
  assign out_o.last       = last_q;
  assign out_o.status     = status_q;

`ifndef SYNTHESIS
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (idx_q == 2'd0))
    else $error("result index left mid-bundle with empty queue");
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q <= head_i.last_idx))
    else $error("result index beyond bundle");
`endif

endmodule

@@ rtl/packbits_difference_volume_decoder_core.sv @@
// Top level of the run-length and difference-coded voxel decoder.
// Usage:
//   in_i   : one compressed byte per transaction; start_of_volume set on the
//            first byte of a volume clears reference, error and run state.
//   cfg_i  : writes bytes_per_voxel (bit 1 set selects 16-bit voxels); always
//            ready, to be written only while the decoder is idle.
//   out_o  : decoded voxels, one per transaction, with repeat count, status and
//            a last flag on the final result caused by each input byte.
// A byte yields zero to four results. The front end decodes one byte per cycle
// while the queue is not full and places its results as one bundle in a
// four-entry queue; the back end hands out one result per cycle from the head
// bundle through the output register while the receiver is ready.
// Throughput: one byte per cycle while bytes produce at most one result each
// and the receiver is ready; otherwise the output port's one result per cycle
// sets the pace. When the receiver stalls the output register holds and the
// queue fills; input ready drops once all four queue entries are taken.
// Reset clears run state, error and reference, and sets one byte per voxel.
module packbits_difference_volume_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbdv_in_if.sink    in_i,
  pbdv_cfg_if.sink   cfg_i,
  pbdv_out_if.source out_o
);

  pbdv_pkg::pbdv_bundle_t push_data, head;
  logic push, full, pop, head_valid;

  pbdv_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (full),
    .push_o   (push),
    .bundle_o (push_data)
  );

  pbdv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  pbdv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

@@ tb/sv/packbits_difference_volume_decoder_core_tb.sv @@
// Self-checking testbench for the run-length and difference-coded voxel decoder.
`timescale 1ns / 100ps

module packbits_difference_volume_decoder_core_tb;

  typedef struct packed {
    logic [15:0] voxel;
    logic [7:0]  rep;
    logic        last;
    logic [1:0]  status;
  } voxel_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       sov;
  } stream_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pbdv_in_if  in_if ();
  pbdv_cfg_if cfg_if ();
  pbdv_out_if out_if ();

  packbits_difference_volume_decoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  stream_byte_t pending_bytes[$];
  voxel_res_t   expected_voxels[$];
  int           queued_bytes = 0;
  int           mismatches   = 0;

  // Shadow decoder state
  logic [1:0]  width_cfg;
  logic [1:0]  run_kind;
  logic [7:0]  run_left;
  logic [7:0]  low_byte;
  logic        low_held;
  logic [9:0]  code_acc;
  logic [3:0]  code_cnt;
  logic [15:0] ref_val;
  logic        ref_ok;
  logic [1:0]  err_code;

  function automatic void clear_run();
    run_kind = pbdv_pkg::PhCtrl;
    run_left = 8'd0;
    low_byte = 8'd0;
    low_held = 1'b0;
    code_acc = 10'd0;
    code_cnt = 4'd0;
  endfunction

  function automatic void start_run(input logic [1:0] kind, input int count);
    run_kind = kind;
    run_left = count[7:0];
    low_held = 1'b0;
    code_acc = 10'd0;
    code_cnt = 4'd0;
  endfunction

  function automatic void count_down();
    if (run_left <= 8'd1) clear_run();
    else run_left = run_left - 8'd1;
  endfunction

  function automatic void reset_model();
    width_cfg = 2'd1;
    clear_run();
    ref_val  = 16'd0;
    ref_ok   = 1'b0;
    err_code = pbdv_pkg::StOk;
  endfunction

  // Work out the results one accepted byte causes and append them to the expectations
  function automatic void decode_byte(input logic [7:0] b, input logic sov);
    voxel_res_t  produced[$];
    voxel_res_t  tail;
    logic        wide;
    logic [15:0] v;
    logic [1:0]  c2;
    int          cnt, acc, c;

    if (sov) begin
      clear_run();
      ref_val  = 16'd0;
      ref_ok   = 1'b0;
      err_code = pbdv_pkg::StOk;
    end
    if (err_code != pbdv_pkg::StOk) begin
      expected_voxels.push_back('{16'd0, 8'd0, 1'b1, err_code});
      return;
    end
    wide = width_cfg[1];

    case (run_kind)
      pbdv_pkg::PhCtrl: begin
        if (!wide) begin
          if (b <= pbdv_pkg::NarrowLitMax) start_run(pbdv_pkg::PhCopy, int'(b) + 1);
          else if (!b[7]) begin
            if (ref_ok) start_run(pbdv_pkg::PhDiff, int'(b) - int'(pbdv_pkg::NarrowDiffOf));
            else err_code = pbdv_pkg::StNoRef;
          end else start_run(pbdv_pkg::PhRep, int'(b & pbdv_pkg::NarrowRepMsk) + 1);
        end else begin
          case (b[7:5])
            3'd0:       start_run(pbdv_pkg::PhCopy, int'(b) + 1);
            3'd1, 3'd2: begin
              if (ref_ok) start_run(pbdv_pkg::PhDiff, int'(b) - int'(pbdv_pkg::WideDiffOf));
              else err_code = pbdv_pkg::StNoRef;
            end
            3'd7:       start_run(pbdv_pkg::PhRep, int'(b & pbdv_pkg::WideRepMsk) + 2);
            default:    err_code = pbdv_pkg::StBadCtrl;
          endcase
        end
        if (err_code != pbdv_pkg::StOk) begin
          produced.push_back('{16'd0, 8'd0, 1'b0, err_code});
        end
      end
      pbdv_pkg::PhCopy, pbdv_pkg::PhRep: begin
        if (wide && !low_held) begin
          low_byte = b;
          low_held = 1'b1;
        end else begin
          v = wide ? {b, low_byte} : {8'h00, b};
          low_held = 1'b0;
          ref_val  = v;
          ref_ok   = 1'b1;
          if (run_kind == pbdv_pkg::PhRep) begin
            produced.push_back('{v, run_left, 1'b0, pbdv_pkg::StOk});
            clear_run();
          end else begin
            produced.push_back('{v, 8'd1, 1'b0, pbdv_pkg::StOk});
            count_down();
          end
        end
      end
      default: begin
        v = ref_val;
        if (!wide) begin
          for (int i = 0; i < 4 && run_kind == pbdv_pkg::PhDiff; i++) begin
            c2 = b[2*i +: 2];
            v  = (c2 == 2'd3) ? v - 16'd1 : v + {14'd0, c2};
            v  = v & 16'h00ff;
            produced.push_back('{v, 8'd1, 1'b0, pbdv_pkg::StOk});
            count_down();
          end
          code_acc = 10'd0;
          code_cnt = 4'd0;
        end else begin
          cnt = int'(code_cnt);
          if (cnt > 2) cnt = 0;
          acc = ((int'(code_acc) & ((1 << cnt) - 1)) << 8) | int'(b);
          cnt += 8;
          // Codes are taken MSB-first from the carried bits and this byte
          while (cnt >= 3 && run_kind == pbdv_pkg::PhDiff) begin
            c = (acc >> (cnt - 3)) & 7;
            cnt -= 3;
            v = (c > 4) ? 16'(int'(v) - (c & 3)) : 16'(int'(v) + c);
            produced.push_back('{v, 8'd1, 1'b0, pbdv_pkg::StOk});
            count_down();
          end
          if (run_kind == pbdv_pkg::PhDiff) begin
            code_acc = 10'(acc & ((1 << cnt) - 1));
            code_cnt = 4'(cnt);
          end
        end
        ref_val = v;
        ref_ok  = 1'b1;
      end
    endcase

    if (produced.size() > 0) begin
      tail = produced.pop_back();
      tail.last = 1'b1;
      produced.push_back(tail);
    end
    foreach (produced[i]) expected_voxels.push_back(produced[i]);
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic sov);
    pending_bytes.push_back('{b, sov});
    queued_bytes++;
  endfunction

  // Mostly well-formed runs with random content, some broken streams and error tails
  function automatic void fill_random(input logic wide, input int n_items);
    int         stop_at, r, cnt, nbytes;
    logic       s, has_ref, need_sov;
    logic [7:0] ctrl;

    stop_at  = queued_bytes + n_items;
    has_ref  = 1'b0;
    need_sov = 1'b1;
    while (queued_bytes < stop_at) begin
      r = int'($urandom_range(0, 99));
      s = need_sov || ($urandom_range(0, 11) == 0);
      need_sov = 1'b0;
      if (s) has_ref = 1'b0;
      if (r < 6) begin
        if (wide && (r % 2 == 1)) ctrl = 8'($urandom_range(8'h60, 8'hdf));
        else begin
          s    = 1'b1;
          ctrl = wide ? 8'($urandom_range(1, 64)) + pbdv_pkg::WideDiffOf
                      : 8'($urandom_range(1, 95)) + pbdv_pkg::NarrowDiffOf;
        end
        queue_byte(ctrl, s);
        repeat ($urandom_range(0, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        need_sov = 1'b1;
      end else if (r < 12) begin
        queue_byte(8'($urandom_range(0, 255)), s);
        repeat ($urandom_range(0, 3))
          queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        need_sov = 1'b1;
      end else if (r < 40 || !has_ref) begin
        cnt = ($urandom_range(0, 9) == 0) ? (wide ? 31 : int'(pbdv_pkg::NarrowLitMax))
                                          : int'($urandom_range(0, 5));
        queue_byte(8'(cnt), s);
        repeat ((cnt + 1) * (wide ? 2 : 1))
          queue_byte(8'($urandom_range(0, 255)), 1'b0);
        has_ref = 1'b1;
      end else if (r < 70) begin
        cnt = ($urandom_range(0, 9) == 0) ? (wide ? 64 : 95)
                                          : int'($urandom_range(1, 10));
        queue_byte(8'(cnt) + (wide ? pbdv_pkg::WideDiffOf : pbdv_pkg::NarrowDiffOf), s);
        nbytes = wide ? (3 * cnt + 7) / 8 : (cnt + 3) / 4;
        repeat (nbytes) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        ctrl = wide ? 8'($urandom_range(8'he0, 8'hff)) : 8'($urandom_range(8'h80, 8'hff));
        queue_byte(ctrl, s);
        repeat (wide ? 2 : 1) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        has_ref = 1'b1;
      end
    end
  endfunction

  // Hold until every byte is taken and every result has come, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_if.valid || expected_voxels.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [1:0] w);
    @(posedge clk_i);
    cfg_if.valid           <= 1'b1;
    cfg_if.bytes_per_voxel <= w;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Byte driver: bursts of random length separated by random gaps
  int           burst_left;
  int           gap_left;
  stream_byte_t next_byte;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid           <= 1'b0;
      in_if.in_byte         <= 8'd0;
      in_if.start_of_volume <= 1'b0;
      burst_left            <= 4;
      gap_left              <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0 || pending_bytes.size() == 0) begin
        in_if.valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        next_byte              = pending_bytes.pop_front();
        in_if.valid           <= 1'b1;
        in_if.in_byte         <= next_byte.b;
        in_if.start_of_volume <= next_byte.sov;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 4) == 0) ? 60 : int'($urandom_range(1, 16));
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Result receiver: stall pattern chosen by the top two bits of a free-running tick counter
  logic [9:0] stall_tick;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_tick   <= 10'd0;
    end else begin
      stall_tick <= stall_tick + 10'd1;
      case (stall_tick[9:8])
        2'd0:    out_if.ready <= 1'b1;
        2'd1:    out_if.ready <= ($urandom_range(0, 9) < 7);
        2'd2:    out_if.ready <= (stall_tick[1:0] == 2'd0);
        default: out_if.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Monitor: track register writes, predict on accepted bytes, check accepted results
  voxel_res_t seen_res;
  voxel_res_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) width_cfg = cfg_if.bytes_per_voxel;
      if (in_if.valid && in_if.ready) decode_byte(in_if.in_byte, in_if.start_of_volume);
      if (out_if.valid && out_if.ready) begin
        seen_res = '{out_if.voxel, out_if.repeat_res, out_if.last, out_if.status};
        if (expected_voxels.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, got voxel %h rep %0d last %0b status %0d",
                   $time, seen_res.voxel, seen_res.rep, seen_res.last, seen_res.status);
        end else begin
          want_res = expected_voxels.pop_front();
          if (seen_res.voxel !== want_res.voxel || seen_res.rep !== want_res.rep ||
              seen_res.last !== want_res.last || seen_res.status !== want_res.status) begin
            mismatches++;
            $display("%0t: expected voxel %h rep %0d last %0b status %0d,",
                     $time, want_res.voxel, want_res.rep, want_res.last, want_res.status);
            $display("%0t: got voxel %h rep %0d last %0b status %0d",
                     $time, seen_res.voxel, seen_res.rep, seen_res.last, seen_res.status);
          end
        end
      end
    end
  end

  logic [1:0] phase_widths[6] = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1};

  initial begin
    cfg_if.valid           = 1'b0;
    cfg_if.bytes_per_voxel = 2'd1;
    rst_ni                 = 1'b0;
    reset_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // One byte per voxel: difference before any reference, then literal,
    // four codes from one byte, longest repeat, and a literal left half done
    queue_byte(8'h35, 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h24, 1'b0);
    queue_byte(8'he4, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h11, 1'b0);
    wait_idle();
    write_width(2'd3);

    // Two bytes per voxel: finish the literal, codes across byte borders,
    // bad control byte held until restart, repeats at both count extremes
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h21, 1'b0);
    queue_byte(8'hbc, 1'b0);
    queue_byte(8'h24, 1'b0);
    queue_byte(8'h8d, 1'b0);
    queue_byte(8'h37, 1'b0);
    queue_byte(8'h60, 1'b0);
    queue_byte(8'hdf, 1'b0);
    queue_byte(8'he0, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h7f, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h77, 1'b0);
    wait_idle();
    // Narrow again with a low byte held: it is ignored
    write_width(2'd0);
    queue_byte(8'h88, 1'b0);
    queue_byte(8'h99, 1'b0);
    wait_idle();
    // Leave code bits over in a wide difference run, then finish it narrow
    write_width(2'd2);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'hff, 1'b0);
    wait_idle();
    write_width(2'd0);
    queue_byte(8'h03, 1'b0);
    wait_idle();

    foreach (phase_widths[i]) begin
      write_width(phase_widths[i]);
      fill_random(phase_widths[i][1], 54);
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_voxels.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
